// File: src/apl_pkg.sv
// ----------------------------------------------------------------------------
// apl_pkg
// Shared constants, sequencer states and result flag group for the anchored
// patience-sorting chain engine.
// ----------------------------------------------------------------------------
package apl_pkg;

  localparam int unsigned MAX_PILES_DEF  = 1024;
  localparam int unsigned MAX_RANGE_DEF  = 65536;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // reported range positions are taken modulo 2^16
  localparam int unsigned POS_W = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_LINK,
    ST_FINISH
  } apl_state_e;

  typedef struct packed {
    logic placed;
    logic has_pred;
    logic overflow;
  } apl_flags_t;

endpackage

// File: src/apl_ram.sv
// ----------------------------------------------------------------------------
// apl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module apl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/apl_core.sv
// ----------------------------------------------------------------------------
// apl_core
// Sequencer for one element: binary search over the pile tops with a single
// shared compare, one read per step, then the pile update and result register.
// ----------------------------------------------------------------------------
module apl_core
  import apl_pkg::*;
#(
  parameter int unsigned MAX_PILES  = MAX_PILES_DEF,
  parameter int unsigned MAX_RANGE  = MAX_RANGE_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  localparam int unsigned AW        = $clog2(MAX_PILES),
  localparam int unsigned CNT_W     = $clog2(MAX_PILES + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  descending_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  range_start_i,
  // pile top memories
  output logic                  val_we_o,
  output logic                  val_re_o,
  output logic [AW-1:0]         val_waddr_o,
  output logic [AW-1:0]         val_raddr_o,
  output logic [VALUE_BITS-1:0] val_wdata_o,
  input  logic [VALUE_BITS-1:0] val_rdata_i,
  output logic                  idx_we_o,
  output logic                  idx_re_o,
  output logic [AW-1:0]         idx_raddr_o,
  output logic [POS_W-1:0]      idx_wdata_o,
  input  logic [POS_W-1:0]      idx_rdata_i,
  // result register
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CNT_W-1:0]      out_len_o,
  output logic [VALUE_BITS-1:0] out_val_o,
  output logic [POS_W-1:0]      out_idx_o,
  output logic [POS_W-1:0]      out_pred_o,
  output apl_flags_t            out_flags_o
);

  localparam int unsigned RC_W = $clog2(MAX_RANGE + 1);

  apl_state_e state_q, state_d;

  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [RC_W-1:0]              ctr_q, ctr_d;
  logic [CNT_W-1:0]             lo_q, lo_d, hi_q, hi_d;
  logic [AW-1:0]                mid_q, mid_d;
  logic                         pend_q, pend_d;
  logic signed [VALUE_BITS-1:0] x_q, x_d;
  logic [POS_W-1:0]             pos_q, pos_d;
  logic [VALUE_BITS-1:0]        best_val_q, best_val_d;
  logic [POS_W-1:0]             best_idx_q, best_idx_d;
  apl_flags_t                   flags_q, flags_d;

  logic                  out_valid_q, out_valid_d;
  logic [CNT_W-1:0]      out_len_q, out_len_d;
  logic [VALUE_BITS-1:0] out_val_q, out_val_d;
  logic [POS_W-1:0]      out_idx_q, out_idx_d;
  logic [POS_W-1:0]      out_pred_q, out_pred_d;
  apl_flags_t            out_flags_q, out_flags_d;

  logic                         accept;
  logic [RC_W-1:0]              ctr_eff;
  logic [CNT_W-1:0]             cnt_eff;
  logic                         range_full;
  logic signed [VALUE_BITS-1:0] top;
  logic                         beyond;
  logic [CNT_W-1:0]             lo_n, hi_n, mid_full, slot_m1;
  logic                         done;
  logic                         skip, piles_full, place;
  logic                         out_load;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  assign ctr_eff    = range_start_i ? '0 : ctr_q;
  assign cnt_eff    = range_start_i ? '0 : cnt_q;
  assign range_full = (ctr_eff >= RC_W'(MAX_RANGE));

  // shared compare: previous read answers, then next probe address
  assign top    = $signed(val_rdata_i);
  assign beyond = descending_i ? (top < x_q) : (x_q < top);

  always_comb begin
    lo_n = lo_q;
    hi_n = hi_q;
    if (pend_q) begin
      if (beyond) begin
        hi_n = CNT_W'(mid_q);
      end else begin
        lo_n = CNT_W'(mid_q) + 1'b1;
      end
    end
  end

  assign mid_full = lo_n + ((hi_n - lo_n) >> 1);
  assign done     = !(lo_n < hi_n);

  // lo_q holds the landing pile once the search is done
  assign skip       = (cnt_q != '0) && (lo_q == '0);
  assign piles_full = (lo_q == CNT_W'(MAX_PILES));
  assign place      = !skip && !piles_full;
  assign slot_m1    = lo_q - 1'b1;

  assign out_load = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = range_full ? ST_FINISH : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (done) begin
          state_d = ST_LINK;
        end
      end
      ST_LINK: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    ctr_d       = ctr_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    pend_d      = pend_q;
    x_d         = x_q;
    pos_d       = pos_q;
    best_val_d  = best_val_q;
    best_idx_d  = best_idx_q;
    flags_d     = flags_q;
    out_valid_d = out_valid_q;
    out_len_d   = out_len_q;
    out_val_d   = out_val_q;
    out_idx_d   = out_idx_q;
    out_pred_d  = out_pred_q;
    out_flags_d = out_flags_q;

    val_we_o    = 1'b0;
    val_re_o    = 1'b0;
    val_waddr_o = lo_q[AW-1:0];
    val_raddr_o = mid_full[AW-1:0];
    val_wdata_o = x_q;
    idx_we_o    = 1'b0;
    idx_re_o    = 1'b0;
    idx_raddr_o = slot_m1[AW-1:0];
    idx_wdata_o = pos_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d   = cnt_eff;
          x_d     = value_i;
          pos_d   = POS_W'(ctr_eff);
          lo_d    = '0;
          hi_d    = cnt_eff;
          pend_d  = 1'b0;
          flags_d = '0;
          if (range_full) begin
            ctr_d            = ctr_eff;
            flags_d.overflow = 1'b1;
          end else begin
            ctr_d = ctr_eff + 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        lo_d     = lo_n;
        hi_d     = hi_n;
        mid_d    = mid_full[AW-1:0];
        pend_d   = !done;
        val_re_o = !done;
      end
      ST_LINK: begin
        val_we_o         = place;
        idx_we_o         = place;
        idx_re_o         = place && (lo_q != '0);
        flags_d.placed   = place;
        flags_d.has_pred = place && (lo_q != '0);
        flags_d.overflow = piles_full;
        if (place && ((lo_q == cnt_q) || (lo_q == cnt_q - 1'b1))) begin
          best_val_d = x_q;
          best_idx_d = pos_q;
        end
        if (place && (lo_q == cnt_q)) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_len_d   = cnt_q;
          out_val_d   = (cnt_q == '0) ? '0 : best_val_q;
          out_idx_d   = (cnt_q == '0) ? '0 : best_idx_q;
          out_pred_d  = flags_q.has_pred ? idx_rdata_i : '0;
          out_flags_d = flags_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ctr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ctr_q       <= ctr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    x_q         <= x_d;
    pos_q       <= pos_d;
    best_val_q  <= best_val_d;
    best_idx_q  <= best_idx_d;
    flags_q     <= flags_d;
    out_len_q   <= out_len_d;
    out_val_q   <= out_val_d;
    out_idx_q   <= out_idx_d;
    out_pred_q  <= out_pred_d;
    out_flags_q <= out_flags_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_len_o   = out_len_q;
  assign out_val_o   = out_val_q;
  assign out_idx_o   = out_idx_q;
  assign out_pred_o  = out_pred_q;
  assign out_flags_o = out_flags_q;

  // search window never grows past the pile count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (hi_q <= cnt_q))
    else $error("search bound beyond pile count");

  // the pile count only moves on a new range or a push
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |=> $stable(cnt_q))
    else $error("pile count changed during search");

  // pile memories are never written outside the update step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (val_we_o || idx_we_o) |-> (state_q == ST_LINK))
    else $error("pile write outside update step");

endmodule

// File: src/anchored_patience_lis_engine.sv
// ----------------------------------------------------------------------------
// anchored_patience_lis_engine
// Longest non-decreasing / non-increasing chain over one range by patience
// sorting, with the range's first element held as a fixed anchor pile.
// ----------------------------------------------------------------------------
// sequence: accept, then a binary search over the pile tops, one probe per step,
//   at most ceil(log2(piles + 1)) probes (11 at 1024 piles), then the pile update
//   and result register; a range-limit refusal skips to the result register
// flow: one item at a time, next item taken the cycle after its result registers
// reset: clears pile count, range position, mode and result valid; the pile
//   memories keep no reset and are bounded by the pile count, no clearing pass
// ----------------------------------------------------------------------------
module anchored_patience_lis_engine
  import apl_pkg::*;
#(
  parameter int unsigned MAX_PILES  = MAX_PILES_DEF,
  parameter int unsigned MAX_RANGE  = MAX_RANGE_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  localparam int unsigned CNT_W     = $clog2(MAX_PILES + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_data_i,
  // input items
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  range_start_i,
  // result items
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CNT_W-1:0]      best_length_o,
  output logic [VALUE_BITS-1:0] best_top_value_o,
  output logic [POS_W-1:0]      best_top_index_o,
  output logic                  placed_o,
  output logic                  has_pred_o,
  output logic [POS_W-1:0]      pred_index_o,
  output logic                  overflow_o
);

  localparam int unsigned AW = $clog2(MAX_PILES);

  logic descending_q;

  logic                  val_we, val_re, idx_we, idx_re;
  logic [AW-1:0]         val_waddr, val_raddr, idx_raddr;
  logic [VALUE_BITS-1:0] val_wdata, val_rdata;
  logic [POS_W-1:0]      idx_wdata, idx_rdata;
  apl_flags_t            out_flags;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      descending_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      descending_q <= cfg_data_i;
    end
  end

  apl_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_PILES)
  ) u_top_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .re_i    (val_re),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  // index store shares the write address with the value store
  apl_ram #(
    .WIDTH (POS_W),
    .DEPTH (MAX_PILES)
  ) u_top_index_ram (
    .clk_i   (clk_i),
    .we_i    (idx_we),
    .waddr_i (val_waddr),
    .wdata_i (idx_wdata),
    .re_i    (idx_re),
    .raddr_i (idx_raddr),
    .rdata_o (idx_rdata)
  );

  apl_core #(
    .MAX_PILES  (MAX_PILES),
    .MAX_RANGE  (MAX_RANGE),
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .descending_i  (descending_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_i       (value_i),
    .range_start_i (range_start_i),
    .val_we_o      (val_we),
    .val_re_o      (val_re),
    .val_waddr_o   (val_waddr),
    .val_raddr_o   (val_raddr),
    .val_wdata_o   (val_wdata),
    .val_rdata_i   (val_rdata),
    .idx_we_o      (idx_we),
    .idx_re_o      (idx_re),
    .idx_raddr_o   (idx_raddr),
    .idx_wdata_o   (idx_wdata),
    .idx_rdata_i   (idx_rdata),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_len_o     (best_length_o),
    .out_val_o     (best_top_value_o),
    .out_idx_o     (best_top_index_o),
    .out_pred_o    (pred_index_o),
    .out_flags_o   (out_flags)
  );

  assign placed_o   = out_flags.placed;
  assign has_pred_o = out_flags.has_pred;
  assign overflow_o = out_flags.overflow;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |-> !placed_o)
    else $error("refused item reported as placed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && has_pred_o) |-> placed_o)
    else $error("predecessor without placement");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && placed_o) |-> (best_length_o != '0))
    else $error("placed item left no pile");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (best_length_o <= CNT_W'(MAX_PILES)))
    else $error("pile count beyond capacity");

endmodule
